// File: rtl/core/billboard_quad_vertex_expand_unit_macros.svh
// Assertion macros shared by the billboard quad expansion RTL.
`ifndef BILLBOARD_QUAD_VERTEX_EXPAND_UNIT_MACROS_SVH
`define BILLBOARD_QUAD_VERTEX_EXPAND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BQVE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqve: same-cycle check failed");
// Next-cycle implication.
`define BQVE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqve: next-cycle check failed");
`else
`define BQVE_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BQVE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/bqve_pkg.sv
package bqve_pkg;

   localparam int REQ_TDATA_W = 272;
   localparam int RSP_TDATA_W = 136;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CORNER_LSB  = 130;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_RIGHT_X = 3'd0;
   localparam reg_index_type REG_RIGHT_Y = 3'd1;
   localparam reg_index_type REG_RIGHT_Z = 3'd2;
   localparam reg_index_type REG_UP_X    = 3'd3;
   localparam reg_index_type REG_UP_Y    = 3'd4;
   localparam reg_index_type REG_UP_Z    = 3'd5;

   typedef logic [1:0] corner_type;
   localparam corner_type CORNER_LEFT_DOWN  = 2'd0;
   localparam corner_type CORNER_LEFT_UP    = 2'd1;
   localparam corner_type CORNER_RIGHT_UP   = 2'd2;
   localparam corner_type CORNER_RIGHT_DOWN = 2'd3;

   // Texture coordinate per corner, indexed by corner number.
   localparam logic [3:0] TEX_U_TABLE = 4'b1100;
   localparam logic [3:0] TEX_V_TABLE = 4'b1001;

   // Round half up before dropping 22 fraction bits (Q.38 -> Q.16).
   localparam logic signed [64:0] ROUND_HALF = 65'sd2097152;
   localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
   localparam logic [31:0] POS_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [15:0] right_x;
      logic [15:0] right_y;
      logic [15:0] right_z;
      logic [15:0] up_x;
      logic [15:0] up_y;
      logic [15:0] up_z;
   } axes_type;

   localparam axes_type AXES_RESET = '{16'h4000, 16'h0000, 16'h0000,
                                       16'h0000, 16'h4000, 16'h0000};

   // Sprite with extents already multiplied by the scale (Q.24, 48 bits).
   typedef struct packed {
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [47:0] left_s;
      logic [47:0] right_s;
      logic [47:0] up_s;
      logic [47:0] down_s;
      logic [31:0] color;
   } sprite_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/core/bqve_front.sv
module bqve_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // origin_x, origin_y, origin_z, extent_left, extent_right, extent_up,
   // extent_down, quad_scale, in_red, in_green, in_blue, in_alpha
   input  logic [bqve_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  bqve_pkg::queue_status_type     q_status,
   output logic                           q_push,
   output bqve_pkg::sprite_type           q_entry
);

   logic                 valid_ff, valid_in;
   bqve_pkg::sprite_type entry_ff;
   logic                 accept;
   logic [15:0]          scale;
   logic signed [48:0]   m_left, m_right, m_up, m_down;

   assign scale  = req_tdata[239:224];
   assign m_left  = $signed(req_tdata[127:96])  * $signed({1'b0, scale});
   assign m_right = $signed(req_tdata[159:128]) * $signed({1'b0, scale});
   assign m_up    = $signed(req_tdata[191:160]) * $signed({1'b0, scale});
   assign m_down  = $signed(req_tdata[223:192]) * $signed({1'b0, scale});

   assign q_push     = valid_ff && !q_status.full;
   assign req_tready = !valid_ff || !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign q_entry    = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         entry_ff.origin_x <= req_tdata[31:0];
         entry_ff.origin_y <= req_tdata[63:32];
         entry_ff.origin_z <= req_tdata[95:64];
         entry_ff.left_s   <= m_left[47:0];
         entry_ff.right_s  <= m_right[47:0];
         entry_ff.up_s     <= m_up[47:0];
         entry_ff.down_s   <= m_down[47:0];
         entry_ff.color    <= req_tdata[271:240];
      end
   end

endmodule

// File: rtl/core/bqve_queue.sv
module bqve_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bqve_pkg::sprite_type       push_entry,
   input  logic                       pop,
   output bqve_pkg::sprite_type       head,
   output bqve_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bqve_pkg::sprite_type entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/bqve_back.sv
module bqve_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bqve_pkg::axes_type             axes,
   input  bqve_pkg::sprite_type           head,
   input  bqve_pkg::queue_status_type     q_status,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, out_red, out_green, out_blue,
   // out_alpha, corner_number, zero fill
   output logic [bqve_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   logic                 advance, issue;
   bqve_pkg::corner_type corner_ff, corner_in;
   logic signed [47:0]   h_sel, v_sel;
   logic signed [15:0]   ra [3];
   logic signed [15:0]   ua [3];
   logic [31:0]          org [3];

   // stage 1: axis products
   logic                 s1_valid_ff;
   logic signed [63:0]   s1_h_ff [3];
   logic signed [63:0]   s1_v_ff [3];
   logic [31:0]          s1_org_ff [3];
   logic [31:0]          s1_color_ff;
   bqve_pkg::corner_type s1_corner_ff;

   // stage 2: rounded sum
   logic                 s2_valid_ff;
   logic signed [64:0]   sum [3];
   logic [42:0]          s2_t_ff [3];
   logic [31:0]          s2_org_ff [3];
   logic [31:0]          s2_color_ff;
   bqve_pkg::corner_type s2_corner_ff;

   // output register: origin added and saturated
   logic                 out_valid_ff;
   logic signed [43:0]   wide [3];
   logic [31:0]          sat [3];
   logic [31:0]          out_pos_ff [3];
   logic [31:0]          out_color_ff;
   bqve_pkg::corner_type out_corner_ff;

   assign ra[0]  = axes.right_x;
   assign ra[1]  = axes.right_y;
   assign ra[2]  = axes.right_z;
   assign ua[0]  = axes.up_x;
   assign ua[1]  = axes.up_y;
   assign ua[2]  = axes.up_z;
   assign org[0] = head.origin_x;
   assign org[1] = head.origin_y;
   assign org[2] = head.origin_z;

   // whole pipe moves when the output slot is free or being taken
   assign advance = !out_valid_ff || rsp_tready;
   assign issue   = advance && !q_status.empty;
   assign q_pop   = issue && (corner_ff == bqve_pkg::CORNER_RIGHT_DOWN);

   always_comb begin
      corner_in = issue ? corner_ff + 2'd1 : corner_ff;
      if (corner_ff == bqve_pkg::CORNER_LEFT_DOWN || corner_ff == bqve_pkg::CORNER_LEFT_UP) begin
         h_sel = head.left_s;
      end else begin
         h_sel = head.right_s;
      end
      if (corner_ff == bqve_pkg::CORNER_LEFT_DOWN
          || corner_ff == bqve_pkg::CORNER_RIGHT_DOWN) begin
         v_sel = head.down_s;
      end else begin
         v_sel = head.up_s;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k]  = 65'(s1_h_ff[k]) + 65'(s1_v_ff[k]) + bqve_pkg::ROUND_HALF;
         wide[k] = 44'($signed(s2_t_ff[k])) + 44'($signed(s2_org_ff[k]));
         if (wide[k][43:31] == {13{wide[k][43]}}) begin
            sat[k] = wide[k][31:0];
         end else if (wide[k][43]) begin
            sat[k] = bqve_pkg::POS_MIN;
         end else begin
            sat[k] = bqve_pkg::POS_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= bqve_pkg::CORNER_LEFT_DOWN;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s1_h_ff[k]    <= h_sel * ra[k];
            s1_v_ff[k]    <= v_sel * ua[k];
            s1_org_ff[k]  <= org[k];
            s2_t_ff[k]    <= sum[k][64:22];
            s2_org_ff[k]  <= s1_org_ff[k];
            out_pos_ff[k] <= sat[k];
         end
         s1_color_ff   <= head.color;
         s1_corner_ff  <= corner_ff;
         s2_color_ff   <= s1_color_ff;
         s2_corner_ff  <= s1_corner_ff;
         out_color_ff  <= s2_color_ff;
         out_corner_ff <= s2_corner_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = (out_corner_ff == bqve_pkg::CORNER_RIGHT_DOWN);
   assign rsp_tdata  = {4'b0000, out_corner_ff, out_color_ff,
                        bqve_pkg::TEX_V_TABLE[out_corner_ff],
                        bqve_pkg::TEX_U_TABLE[out_corner_ff],
                        out_pos_ff[2], out_pos_ff[1], out_pos_ff[0]};

endmodule

// File: rtl/core/billboard_quad_vertex_expand_unit.sv
// Expands one sprite into four quad vertices (left-down, left-up, right-up,
// right-down), one vertex per clock on the result stream while the result
// side is ready, with tlast on the fourth. A sprite holds the single result
// port for its four vertices, and sprites stream back to back as long as the
// result side is ready. The front stage scales the four extents and parks the
// sprite in a QUEUE_DEPTH-entry queue; the back end walks the corners through
// a three-register pipe (axis products, rounded sum, origin add with
// saturation); a sprite passes the front register, the queue and these three
// registers in turn. The user must write the six view axes through the csr
// port only while no sprite is in flight; the block does not enforce this.
`include "billboard_quad_vertex_expand_unit_macros.svh"

module billboard_quad_vertex_expand_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // origin_x, origin_y, origin_z, extent_left, extent_right, extent_up,
   // extent_down, quad_scale, in_red, in_green, in_blue, in_alpha
   input  logic [bqve_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, out_red, out_green, out_blue,
   // out_alpha, corner_number, zero fill
   output logic [bqve_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bqve_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bqve_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bqve_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   bqve_pkg::axes_type         axes_ff, axes_in;
   bqve_pkg::reg_index_type    csr_index;
   logic                       csr_write;
   logic [15:0]                rd_value;
   logic                       q_push, q_pop;
   bqve_pkg::sprite_type       q_entry, q_head;
   bqve_pkg::queue_status_type q_status;
   logic                       rsp_hs;
   logic [1:0]                 rsp_corner;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      axes_in = axes_ff;
      if (csr_write) begin
         case (csr_index)
            bqve_pkg::REG_RIGHT_X: axes_in.right_x = csr_pwdata[15:0];
            bqve_pkg::REG_RIGHT_Y: axes_in.right_y = csr_pwdata[15:0];
            bqve_pkg::REG_RIGHT_Z: axes_in.right_z = csr_pwdata[15:0];
            bqve_pkg::REG_UP_X:    axes_in.up_x    = csr_pwdata[15:0];
            bqve_pkg::REG_UP_Y:    axes_in.up_y    = csr_pwdata[15:0];
            bqve_pkg::REG_UP_Z:    axes_in.up_z    = csr_pwdata[15:0];
            default:               axes_in = axes_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bqve_pkg::REG_RIGHT_X: rd_value = axes_ff.right_x;
         bqve_pkg::REG_RIGHT_Y: rd_value = axes_ff.right_y;
         bqve_pkg::REG_RIGHT_Z: rd_value = axes_ff.right_z;
         bqve_pkg::REG_UP_X:    rd_value = axes_ff.up_x;
         bqve_pkg::REG_UP_Y:    rd_value = axes_ff.up_y;
         bqve_pkg::REG_UP_Z:    rd_value = axes_ff.up_z;
         default:               rd_value = '0;
      endcase
   end

   assign csr_prdata = {16'h0000, rd_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         axes_ff <= bqve_pkg::AXES_RESET;
      end else begin
         axes_ff <= axes_in;
      end
   end

   bqve_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   bqve_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   bqve_back u_back (
      .clock      (clock),
      .reset      (reset),
      .axes       (axes_ff),
      .head       (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_hs     = rsp_tvalid && rsp_tready;
   assign rsp_corner = rsp_tdata[bqve_pkg::CORNER_LSB +: 2];

   `BQVE_ASSERT_IMPLY(a_push_has_room, clock, reset, q_push, !q_status.full)
   `BQVE_ASSERT_IMPLY(a_pop_has_entry, clock, reset, q_pop, !q_status.empty)
   `BQVE_ASSERT_NEXT(a_corner_seq, clock, reset, rsp_hs, !rsp_tvalid || rsp_corner == $past(rsp_corner) + 2'd1)

endmodule
